>>> rtl/one_euro_filter_macros.svh
// ---------------------------------------------------------------------------
// one_euro_filter_macros
// Assertion helpers shared by the filter RTL.
// All checks sample on clk and are disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ONE_EURO_FILTER_MACROS_SVH
`define ONE_EURO_FILTER_MACROS_SVH

// A condition that must hold at every clock edge.
`define OEF_ASSERT_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that must hold in the cycle after the trigger.
`define OEF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/oef_pkg.sv
// ---------------------------------------------------------------------------
// oef_pkg
// Types and constants of the one-euro filter: unit request bundles and the
// fixed-point constants.
// ---------------------------------------------------------------------------
package oef_pkg;

  localparam int FRAC_BITS = 16;

  // Widths of the shared units
  localparam int DVD_W = 54;  // dividend shift register
  localparam int DSR_W = 38;  // divisor / remainder
  localparam int CNT_W = 6;   // division step count
  localparam int MA_W  = 49;  // multiplicand
  localparam int MB_W  = 32;  // multiplier
  localparam int MP_W  = MA_W + MB_W;

  localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
  // 1e6 * 2^32/(2*pi) scaled to Q.F, rounded
  localparam logic [35:0] ALPHA_D =
    36'((64'd1000000 * 64'd683565276 + 64'd32768) >> (32 - FRAC_BITS));
  localparam logic [17:0] QUARTER_SEC = 18'd250000;

  typedef struct packed {
    logic             start;
    logic [DSR_W-1:0] rem_init;
    logic [DVD_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
    logic [CNT_W-1:0] count;
  } div_req_t;

  typedef struct packed {
    logic            start;
    logic [MA_W-1:0] a;
    logic [MB_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

>>> rtl/oef_div.sv
// ---------------------------------------------------------------------------
// oef_div
// Restoring divider, one quotient bit per cycle. The remainder may be
// preloaded so a fraction num/den with num < den takes only F steps.
// ---------------------------------------------------------------------------
module oef_div
  import oef_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  output unit_stat_t       stat,
  output logic [DVD_W-1:0] quo
);

  logic [DSR_W-1:0] rem_r, rem_nxt;
  logic [DVD_W-1:0] dvd_r;
  logic [DVD_W-1:0] quo_r;
  logic [DSR_W-1:0] dsr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DSR_W:0]   shifted;
  logic             qbit;

  // one trial subtraction
  always_comb begin
    shifted = {rem_r, dvd_r[DVD_W-1]};
    qbit    = shifted >= {1'b0, dsr_r};
    rem_nxt = qbit ? DSR_W'(shifted - {1'b0, dsr_r}) : shifted[DSR_W-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.count;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.rem_init;
      dvd_r <= req.dividend;
      dsr_r <= req.divisor;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      quo_r <= {quo_r[DVD_W-2:0], qbit};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quo       = quo_r;

endmodule

>>> rtl/oef_mul.sv
// ---------------------------------------------------------------------------
// oef_mul
// Shared multiplier: a 49 x 16 array used twice, low then high half of the
// multiplier, partial product registered before accumulation.
// ---------------------------------------------------------------------------
module oef_mul
  import oef_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  mul_req_t        req,
  output unit_stat_t      stat,
  output logic [MP_W-1:0] prod
);

  localparam int HB = MB_W / 2;
  localparam int PP_W = MA_W + HB;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_LO   = 2'd1;
  localparam logic [1:0] PH_HI   = 2'd2;
  localparam logic [1:0] PH_ACC  = 2'd3;

  logic [1:0]      ph_r;
  logic            done_r;
  logic [MA_W-1:0] a_r;
  logic [MB_W-1:0] b_r;
  logic [PP_W-1:0] pp_r;
  logic [MP_W-1:0] acc_r;
  logic [HB-1:0]   b_half;

  assign b_half = (ph_r == PH_LO) ? b_r[HB-1:0] : b_r[MB_W-1:HB];

  // phase control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (ph_r)
        PH_IDLE: if (req.start) ph_r <= PH_LO;
        PH_LO:   ph_r <= PH_HI;
        PH_HI:   ph_r <= PH_ACC;
        PH_ACC: begin
          ph_r   <= PH_IDLE;
          done_r <= 1'b1;
        end
        default: ph_r <= PH_IDLE;
      endcase
    end
  end

  // operands, partial product and accumulator
  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r <= req.a;
      b_r <= req.b;
    end
    if (ph_r == PH_LO || ph_r == PH_HI) begin
      pp_r <= a_r * b_half;
    end
    if (ph_r == PH_HI) begin
      acc_r <= MP_W'(pp_r);
    end else if (ph_r == PH_ACC) begin
      acc_r <= acc_r + (MP_W'(pp_r) << HB);
    end
  end

  assign stat.busy = (ph_r != PH_IDLE);
  assign stat.done = done_r;
  assign prod      = acc_r;

endmodule

>>> rtl/one_euro_filter.sv
// ---------------------------------------------------------------------------
// one_euro_filter
// Adaptive one-euro low-pass filter over timestamped Q16.16 samples.
// ---------------------------------------------------------------------------
// A restart beat is taken and produces nothing. The first sample after reset
// or restart is taken and its result loaded into the output register in state
// S_OUT. Every later sample runs through a small sequencer that shares one
// bit-serial divider and one two-pass multiplier, and holds the input stalled
// from accept to result: an 18-step divide for the quarter-period dt floor, a
// 53-step divide for the raw derivative, two 16-step divides for the smoothing
// factors, normalizing right shifts before each of those, six multiplies and
// the register updates in between. The divider runs one quotient bit per
// cycle. The next input beat is taken the cycle after the result is loaded.
// A result waits in the output register; the sequencer only holds off when a
// new result is ready while the previous one is still unclaimed.
// ---------------------------------------------------------------------------
module one_euro_filter
  import oef_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  // input beats
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic signed [31:0] in_sample_value,
  input  logic [31:0] in_time_stamp_us,
  // result beats
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] out_filtered_value
);

  `include "one_euro_filter_macros.svh"

  localparam logic [1:0] REG_RATE  = 2'd0;
  localparam logic [1:0] REG_MINC  = 2'd1;
  localparam logic [1:0] REG_BETA  = 2'd2;
  localparam logic [1:0] REG_DCUT  = 2'd3;

  localparam logic OP_RESTART = 1'b1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LO   = 4'd1;
  localparam logic [3:0] S_QMUL = 4'd2;
  localparam logic [3:0] S_QDIV = 4'd3;
  localparam logic [3:0] S_KMUL = 4'd4;
  localparam logic [3:0] S_NORM = 4'd5;
  localparam logic [3:0] S_ADIV = 4'd6;
  localparam logic [3:0] S_DUPD = 4'd7;
  localparam logic [3:0] S_DSUM = 4'd8;
  localparam logic [3:0] S_CMUL = 4'd9;
  localparam logic [3:0] S_CSUM = 4'd10;
  localparam logic [3:0] S_VUPD = 4'd11;
  localparam logic [3:0] S_VSUM = 4'd12;
  localparam logic [3:0] S_OUT  = 4'd13;

  localparam logic [47:0] D48_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] D48_MIN = 48'h8000_0000_0000;
  localparam logic [31:0] V_MAX   = 32'h7FFF_FFFF;
  localparam logic [31:0] V_MIN   = 32'h8000_0000;
  localparam logic [31:0] CUT_CAP = 32'hFFFF_FFFF;
  localparam logic [MP_W-1:0] HALF_LSB = MP_W'(1) << (FRAC_BITS - 1);

  // configuration registers
  logic [13:0] rate_r;
  logic [31:0] minc_r, beta_r, dcut_r;

  // filter state
  logic        primed_r;
  logic [31:0] sv_r;
  logic [47:0] sd_r;
  logic [31:0] last_r;

  // per-sample working registers
  logic [3:0]  state_r;
  logic [31:0] v_r, t_r;
  logic [19:0] dt_r;
  logic        neg_r;
  logic        vpass_r;
  logic [47:0] raw_r;
  logic [52:0] num_r, den_r;
  logic [64:0] rnd_r;
  logic        out_valid_r;
  logic [31:0] out_value_r;

  // shared units
  div_req_t         div_req;
  unit_stat_t       div_stat;
  logic [DVD_W-1:0] div_quo;
  mul_req_t         mul_req;
  unit_stat_t       mul_stat;
  logic [MP_W-1:0]  mul_p;

  // datapath helpers
  logic        in_take;
  logic        out_load;
  logic [13:0] f_eff;
  logic [17:0] lo_num;
  logic [31:0] diff_t;
  logic [19:0] dt_sel;
  logic [32:0] dv, dv_mag;
  logic [48:0] e, e_mag;
  logic [47:0] raw_sel;
  logic [64:0] rnd;
  logic [49:0] sd_sum;
  logic [47:0] sd_new, sd_mag;
  logic [31:0] term;
  logic [32:0] cut_sum;
  logic [31:0] cutoff;
  logic [33:0] sv_sum;
  logic [31:0] sv_new;

  assign in_take = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);
  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  oef_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .stat (div_stat),
    .quo  (div_quo)
  );

  oef_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mul_req),
    .stat (mul_stat),
    .prod (mul_p)
  );

  // dt floor and clamp
  always_comb begin
    f_eff  = (rate_r == 14'd0) ? 14'd1 : rate_r;
    lo_num = QUARTER_SEC + 18'(f_eff >> 1);
    diff_t = t_r - last_r;
    if (diff_t[31] || diff_t < {14'd0, div_quo[17:0]}) begin
      dt_sel = {2'd0, div_quo[17:0]};
    end else if (diff_t > {12'd0, USEC_PER_SEC}) begin
      dt_sel = USEC_PER_SEC;
    end else begin
      dt_sel = diff_t[19:0];
    end
  end

  // differences and magnitudes
  always_comb begin
    dv     = {v_r[31], v_r} - {sv_r[31], sv_r};
    dv_mag = dv[32] ? (33'd0 - dv) : dv;
    e      = {raw_r[47], raw_r} - {sd_r[47], sd_r};
    e_mag  = e[48] ? (49'd0 - e) : e;
    if (div_quo > {6'd0, D48_MAX}) begin
      raw_sel = neg_r ? D48_MIN : D48_MAX;
    end else begin
      raw_sel = neg_r ? (48'd0 - div_quo[47:0]) : div_quo[47:0];
    end
    rnd = 65'((mul_p + HALF_LSB) >> FRAC_BITS);
  end

  // derivative update with saturation
  always_comb begin
    if (neg_r) sd_sum = {{2{sd_r[47]}}, sd_r} - {1'b0, rnd_r[48:0]};
    else       sd_sum = {{2{sd_r[47]}}, sd_r} + {1'b0, rnd_r[48:0]};
    if (!sd_sum[49] && sd_sum[48:47] != 2'b00)     sd_new = D48_MAX;
    else if (sd_sum[49] && sd_sum[48:47] != 2'b11) sd_new = D48_MIN;
    else                                           sd_new = sd_sum[47:0];
    sd_mag = sd_new[47] ? (48'd0 - sd_new) : sd_new;
  end

  // adaptive cutoff
  always_comb begin
    term    = (rnd_r[64:32] != '0) ? CUT_CAP : rnd_r[31:0];
    cut_sum = {1'b0, minc_r} + {1'b0, term};
    cutoff  = cut_sum[32] ? CUT_CAP : cut_sum[31:0];
  end

  // value update with saturation
  always_comb begin
    if (neg_r) sv_sum = {{2{sv_r[31]}}, sv_r} - {1'b0, rnd_r[32:0]};
    else       sv_sum = {{2{sv_r[31]}}, sv_r} + {1'b0, rnd_r[32:0]};
    if (!sv_sum[33] && sv_sum[32:31] != 2'b00)     sv_new = V_MAX;
    else if (sv_sum[33] && sv_sum[32:31] != 2'b11) sv_new = V_MIN;
    else                                           sv_new = sv_sum[31:0];
  end

  // unit requests
  always_comb begin
    div_req = '0;
    mul_req = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_take && in_opcode != OP_RESTART && primed_r) begin
          div_req.start    = 1'b1;
          div_req.dividend = {lo_num, 36'd0};
          div_req.divisor  = {24'd0, f_eff};
          div_req.count    = CNT_W'(18);
        end
      end
      S_LO: begin
        if (div_stat.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = {16'd0, dv_mag};
          mul_req.b     = {12'd0, USEC_PER_SEC};
        end
      end
      S_QMUL: begin
        if (mul_stat.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = {mul_p[52:0], 1'b0};
          div_req.divisor  = {18'd0, dt_r};
          div_req.count    = CNT_W'(53);
        end
      end
      S_QDIV: begin
        if (div_stat.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = {17'd0, dcut_r};
          mul_req.b     = {12'd0, dt_r};
        end
      end
      S_NORM: begin
        if (den_r[52:38] == '0) begin
          div_req.start    = 1'b1;
          div_req.rem_init = num_r[37:0];
          div_req.divisor  = den_r[37:0];
          div_req.count    = CNT_W'(FRAC_BITS);
        end
      end
      S_ADIV: begin
        if (div_stat.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = vpass_r ? {16'd0, dv_mag} : e_mag;
          mul_req.b     = {16'd0, div_quo[15:0]};
        end
      end
      S_DSUM: begin
        mul_req.start = 1'b1;
        mul_req.a     = {1'b0, sd_mag};
        mul_req.b     = beta_r;
      end
      S_CSUM: begin
        mul_req.start = 1'b1;
        mul_req.a     = {17'd0, cutoff};
        mul_req.b     = {12'd0, dt_r};
      end
      default: begin
        div_req = '0;
        mul_req = '0;
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= 14'd30;
      minc_r <= 32'h0001_0000;
      beta_r <= 32'd0;
      dcut_r <= 32'h0001_0000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RATE: rate_r <= cfg_wdata[13:0];
        REG_MINC: minc_r <= cfg_wdata;
        REG_BETA: beta_r <= cfg_wdata;
        REG_DCUT: dcut_r <= cfg_wdata;
        default:  rate_r <= rate_r;
      endcase
    end
  end

  // output register valid: set on load, cleared once the beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // sequencer and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      primed_r    <= 1'b0;
      sv_r        <= '0;
      sd_r        <= '0;
      last_r      <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_take) begin
            if (in_opcode == OP_RESTART) begin
              primed_r <= 1'b0;
              sv_r     <= '0;
              sd_r     <= '0;
            end else if (!primed_r) begin
              primed_r <= 1'b1;
              sv_r     <= in_sample_value;
              sd_r     <= '0;
              last_r   <= in_time_stamp_us;
              state_r  <= S_OUT;
            end else begin
              v_r     <= in_sample_value;
              t_r     <= in_time_stamp_us;
              state_r <= S_LO;
            end
          end
        end
        S_LO: begin
          if (div_stat.done) begin
            dt_r    <= dt_sel;
            last_r  <= t_r;
            neg_r   <= dv[32];
            state_r <= S_QMUL;
          end
        end
        S_QMUL: if (mul_stat.done) state_r <= S_QDIV;
        S_QDIV: begin
          if (div_stat.done) begin
            raw_r   <= raw_sel;
            vpass_r <= 1'b0;
            state_r <= S_KMUL;
          end
        end
        S_KMUL: begin
          if (mul_stat.done) begin
            num_r   <= mul_p[52:0];
            den_r   <= mul_p[52:0] + 53'(ALPHA_D);
            state_r <= S_NORM;
          end
        end
        S_NORM: begin
          if (den_r[52:38] != '0) begin
            num_r <= num_r >> 1;
            den_r <= den_r >> 1;
          end else begin
            state_r <= S_ADIV;
          end
        end
        S_ADIV: begin
          if (div_stat.done) begin
            neg_r   <= vpass_r ? dv[32] : e[48];
            state_r <= vpass_r ? S_VUPD : S_DUPD;
          end
        end
        S_DUPD: begin
          if (mul_stat.done) begin
            rnd_r   <= rnd;
            state_r <= S_DSUM;
          end
        end
        S_DSUM: begin
          sd_r    <= sd_new;
          state_r <= S_CMUL;
        end
        S_CMUL: begin
          if (mul_stat.done) begin
            rnd_r   <= rnd;
            state_r <= S_CSUM;
          end
        end
        S_CSUM: begin
          vpass_r <= 1'b1;
          state_r <= S_KMUL;
        end
        S_VUPD: begin
          if (mul_stat.done) begin
            rnd_r   <= rnd;
            state_r <= S_VSUM;
          end
        end
        S_VSUM: begin
          sv_r    <= sv_new;
          state_r <= S_OUT;
        end
        S_OUT: begin
          // load the output register once the previous beat has left
          if (out_load) begin
            out_value_r <= sv_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_filtered_value = out_value_r;

  // checks
  `OEF_ASSERT_HOLDS(a_units_exclusive, !(mul_stat.busy && div_stat.busy),
    "divider and multiplier busy together")
  `OEF_ASSERT_NEXT(a_restart_unprimes, in_take && in_opcode == OP_RESTART,
    !primed_r && sv_r == '0 && sd_r == '0, "restart left filter state")
  `OEF_ASSERT_HOLDS(a_dt_range,
    state_r != S_QMUL || (dt_r != 20'd0 && dt_r <= USEC_PER_SEC),
    "dt outside its clamp range")
  `OEF_ASSERT_HOLDS(a_alpha_below_one,
    !(state_r == S_ADIV && div_stat.done) || div_quo[DVD_W-1:FRAC_BITS] == '0,
    "smoothing factor not below one")

endmodule
